>>> src/sts_pkg.sv
`default_nettype none

package sts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CFG_W       = 11;
  localparam int INDEX_W     = 10;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = ((INDEX_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

  // Signed window bounds: wide enough for the depth itself, the saturated
  // count, minus one and the sum of both bounds.
  localparam int PTR_W = ((ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W) + 1;

  typedef logic signed [PTR_W-1:0]  ptr_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam data_t NOT_FOUND_VALUE = -32'sd1;

endpackage

`default_nettype wire

>>> src/sts_ram.sv
`default_nettype none

module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> src/sorted_table_binary_search.sv
// Channel | Direction | tdata (low bit first)              | tuser
// in_     | slave     | index[9:0], value[41:10], zero pad | op
// out_    | master    | match_value[31:0]                  | found
// cfg_    | write     | entries_in_use[10:0]               | -
//
// A write word is written to the table when it is accepted. A search word
// makes at most log2(TABLE_DEPTH)+1 table probes and then a result state;
// the single-port table memory allows one probe per cycle.
// Reset clears the control state and the count; table contents are undefined
// until written. A result waits in the output register while the next word is
// accepted; a search that finishes while that register is full holds there.

`default_nettype none

module sorted_table_binary_search (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [sts_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [sts_pkg::IN_TDATA_W-1:0]     in_tdata,  // index, value, pad
  input  wire logic                               in_tuser,  // op
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [sts_pkg::OUT_TDATA_W-1:0]    out_tdata, // match_value
  output logic                                    out_tuser  // found
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [sts_pkg::CFG_W-1:0]  count_r, count_nxt;
  sts_pkg::ptr_t              lo_r, lo_nxt, hi_r, hi_nxt;
  sts_pkg::data_t             key_r, key_nxt;
  logic                       res_found_r, res_found_nxt;
  sts_pkg::data_t             res_value_r, res_value_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic                       out_found_r, out_found_nxt;
  sts_pkg::data_t             out_value_r, out_value_nxt;

  logic [sts_pkg::INDEX_W-1:0] in_index;
  sts_pkg::data_t              in_value;
  logic                        in_accept;
  sts_pkg::ptr_t               count_ext, depth_ext, n_sat, mid_sum;
  sts_pkg::ptr_t               probe_lo, probe_hi;
  logic                        ram_we;
  sts_pkg::addr_t              ram_addr;
  logic [sts_pkg::DATA_W-1:0]  ram_rdata;
  sts_pkg::data_t              entry;
  logic                        out_free;

  assign in_index  = in_tdata[sts_pkg::INDEX_W-1:0];
  assign in_value  = in_tdata[sts_pkg::INDEX_W +: sts_pkg::DATA_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign entry     = ram_rdata;
  assign out_free  = !out_tvalid_r || out_tready;

  assign count_ext = sts_pkg::ptr_t'(count_r);
  assign depth_ext = sts_pkg::ptr_t'(sts_pkg::TABLE_DEPTH);
  assign n_sat     = (count_ext > depth_ext) ? depth_ext : count_ext;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cfg_we ? cfg_wdata : count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_value_nxt = res_value_r;
    ram_we        = 1'b0;
    probe_lo      = lo_r;
    probe_hi      = hi_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_tuser == sts_pkg::OP_WRITE) begin
            ram_we = sts_pkg::ptr_t'(in_index) < depth_ext;
          end else begin
            key_nxt  = in_value;
            lo_nxt   = '0;
            hi_nxt   = n_sat - sts_pkg::ptr_t'(1);
            probe_lo = lo_nxt;
            probe_hi = hi_nxt;
            if (hi_nxt < lo_nxt) begin
              res_found_nxt = 1'b0;
              res_value_nxt = sts_pkg::NOT_FOUND_VALUE;
              state_nxt     = S_RESULT;
            end else begin
              state_nxt = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        if (entry == key_r) begin
          res_found_nxt = 1'b1;
          res_value_nxt = entry;
          state_nxt     = S_RESULT;
        end else begin
          if (entry < key_r) begin
            lo_nxt = mid_sum >>> 1;
            lo_nxt = lo_nxt + sts_pkg::ptr_t'(1);
          end else begin
            hi_nxt = mid_sum >>> 1;
            hi_nxt = hi_nxt - sts_pkg::ptr_t'(1);
          end
          probe_lo = lo_nxt;
          probe_hi = hi_nxt;
          if (hi_nxt < lo_nxt) begin
            res_found_nxt = 1'b0;
            res_value_nxt = sts_pkg::NOT_FOUND_VALUE;
            state_nxt     = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The sum of the current window's bounds; half of it is the middle, which in
  // the probe state is the entry whose data arrives from the memory this cycle.
  assign mid_sum = lo_r + hi_r;

  always_comb begin
    sts_pkg::ptr_t next_sum;
    next_sum = probe_lo + probe_hi;
    if (state_r == S_IDLE && in_tuser == sts_pkg::OP_WRITE) begin
      ram_addr = sts_pkg::addr_t'(in_index);
    end else begin
      ram_addr = sts_pkg::addr_t'(next_sum >>> 1);
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    if (state_r == S_RESULT && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_found_nxt  = res_found_r;
      out_value_nxt  = res_value_r;
    end
  end

  sts_ram #(
    .WIDTH(sts_pkg::DATA_W),
    .DEPTH(sts_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_value_r <= res_value_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = sts_pkg::OUT_TDATA_W'(out_value_r);

endmodule

`default_nettype wire
